// ----- src/vmc_pkg.sv -----
// Shared types and constants for the vertical motion classifier.
package vmc_pkg;

   // Field widths.
   localparam int ALT_W    = 21;
   localparam int TIME_W   = 32;
   localparam int SPEED_W  = 32;
   localparam int THR_W    = 17;
   localparam int TOL_W    = 20;
   localparam int CSR_W    = 20;
   localparam int CSR_IDX_W = 2;

   // Altitude difference is one bit wider than the altitude.
   localparam int DIFF_W   = ALT_W + 1;
   localparam int SCALE_W  = 14;
   localparam int PROD_W   = DIFF_W + SCALE_W;
   localparam int CNT_W    = $clog2(PROD_W + 1);

   // Converts centimeters per millisecond to micrometers per millisecond.
   localparam logic [SCALE_W-1:0] CM_TO_UM = SCALE_W'(10000);

   // Register reset values.
   localparam logic             ENABLE_RESET    = 1'b1;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(100);
   localparam logic [TOL_W-1:0] TOLERANCE_RESET = TOL_W'(10000);

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = CSR_IDX_W'(2);

   typedef enum logic [1:0] {
      STATUS_STOPPED  = 2'd0,
      STATUS_ACCEL    = 2'd1,
      STATUS_STEADY   = 2'd2,
      STATUS_STOPPING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } direction_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_DIVIDE,
      ST_CLASSIFY
   } state_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [TIME_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- src/vmc_divider.sv -----
// Restoring divider that produces one quotient bit per cycle.
module vmc_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  vmc_pkg::div_req_type  div_req,
   output vmc_pkg::div_rsp_type  div_rsp
);

   logic [vmc_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [vmc_pkg::TIME_W-1:0] rem_ff, rem_in;
   logic [vmc_pkg::PROD_W-1:0] quo_ff, quo_in;
   logic [vmc_pkg::TIME_W-1:0] divisor_ff, divisor_in;

   logic [vmc_pkg::TIME_W:0]   trial;
   logic [vmc_pkg::TIME_W:0]   trial_sub;
   logic                       trial_ge;

   // The remainder stays below the divisor, so the shifted trial value fits one extra bit.
   always_comb begin
      trial     = {rem_ff, quo_ff[vmc_pkg::PROD_W-1]};
      trial_ge  = (trial >= {1'b0, divisor_ff});
      trial_sub = trial - {1'b0, divisor_ff};
   end

   always_comb begin
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         count_in   = vmc_pkg::CNT_W'(vmc_pkg::PROD_W);
         busy_in    = 1'b1;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = trial_ge ? trial_sub[vmc_pkg::TIME_W-1:0] : trial[vmc_pkg::TIME_W-1:0];
         quo_in   = {quo_ff[vmc_pkg::PROD_W-2:0], trial_ge};
         count_in = count_ff - vmc_pkg::CNT_W'(1);
         if (count_ff == vmc_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- src/vertical_motion_classifier.sv -----
// Top level of the vertical motion classifier.
//
//   channel | prefix | direction | contents
//   request | req_   | in        | altitude_cm, time_ms
//   result  | rsp_   | out       | motion_status, motion_direction, speed_out, changed
//   config  | csr_   | in        | enable, direction threshold, speed tolerance
//
// A transaction runs from acceptance to result through the differences, the scaling multiply
// that starts the divider, the bit-serial divider (36 quotient bits, then a completion flag)
// and the classify step. One item is in flight at a time: a new request is not taken until
// the block is ready again, which happens in the cycle the result appears.
// Reset is synchronous; it clears the reference, the reported values and the result valid flag,
// and loads the configuration registers with their reset values. A waiting result holds in the
// output register while the next request is taken; only the classify step waits for it to be free.
// With enable low a request is accepted and dropped without a result.
module vertical_motion_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [vmc_pkg::ALT_W-1:0]   req_altitude_cm,
   input  logic        [vmc_pkg::TIME_W-1:0]  req_time_ms,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic        [1:0]                  rsp_motion_status,
   output logic        [1:0]                  rsp_motion_direction,
   output logic        [vmc_pkg::SPEED_W-1:0] rsp_speed_out,
   output logic                               rsp_changed,
   input  logic                               csr_write,
   input  logic        [vmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [vmc_pkg::CSR_W-1:0]   csr_data
);

   vmc_pkg::state_type state_ff, state_in;

   logic                          enable_ff;
   logic [vmc_pkg::THR_W-1:0]     threshold_ff;
   logic [vmc_pkg::TOL_W-1:0]     tolerance_ff;

   logic signed [vmc_pkg::ALT_W-1:0]  ref_alt_ff;
   logic [vmc_pkg::TIME_W-1:0]        ref_time_ff;
   logic [vmc_pkg::SPEED_W-1:0]       ref_speed_ff;
   logic                              primed_ff;
   vmc_pkg::status_type               shown_status_ff;
   vmc_pkg::direction_type            shown_dir_ff;
   logic [vmc_pkg::SPEED_W-1:0]       shown_speed_ff;

   logic signed [vmc_pkg::ALT_W-1:0]  alt_ff;
   logic [vmc_pkg::TIME_W-1:0]        time_ff;
   logic signed [vmc_pkg::DIFF_W-1:0] diff_ff;
   logic [vmc_pkg::TIME_W-1:0]        dt_ff;

   logic                              rsp_valid_ff;
   vmc_pkg::status_type               rsp_status_ff;
   vmc_pkg::direction_type            rsp_dir_ff;
   logic [vmc_pkg::SPEED_W-1:0]       rsp_speed_ff;
   logic                              rsp_changed_ff;

   logic                              req_take;
   logic                              div_start;
   logic                              cls_fire;
   logic [vmc_pkg::TIME_W-1:0]        now;
   logic signed [vmc_pkg::DIFF_W-1:0] diff_calc;
   logic [vmc_pkg::TIME_W-1:0]        dt_calc;
   logic [vmc_pkg::DIFF_W-1:0]        distance;

   vmc_pkg::div_req_type              div_req;
   vmc_pkg::div_rsp_type              div_rsp;

   logic [vmc_pkg::SPEED_W-1:0]       speed;
   logic [vmc_pkg::SPEED_W:0]         speed_ext;
   logic [vmc_pkg::SPEED_W:0]         tol_ext;
   logic [vmc_pkg::SPEED_W:0]         refs_ext;
   logic signed [vmc_pkg::DIFF_W:0]   diff_ext;
   logic signed [vmc_pkg::DIFF_W:0]   thr_ext;
   vmc_pkg::status_type               new_status;
   vmc_pkg::direction_type            new_dir;
   logic                              changed;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vmc_pkg::ST_IDLE: begin
            if (req_valid && enable_ff) begin
               state_in = vmc_pkg::ST_DIFF;
            end
         end
         vmc_pkg::ST_DIFF:   state_in = vmc_pkg::ST_MUL;
         vmc_pkg::ST_MUL:    state_in = vmc_pkg::ST_DIVIDE;
         vmc_pkg::ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = vmc_pkg::ST_CLASSIFY;
            end
         end
         vmc_pkg::ST_CLASSIFY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = vmc_pkg::ST_IDLE;
            end
         end
         default: state_in = vmc_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      cls_fire  = 1'b0;
      case (state_ff)
         vmc_pkg::ST_IDLE:     req_ready = 1'b1;
         vmc_pkg::ST_MUL:      div_start = 1'b1;
         vmc_pkg::ST_CLASSIFY: cls_fire  = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_take = req_valid && req_ready && enable_ff;
   assign now      = req_time_ms[vmc_pkg::TIME_W-1:0];

   // Differences against the reference, and the scaled distance for the divider.
   always_comb begin
      diff_calc = $signed({alt_ff[vmc_pkg::ALT_W-1], alt_ff})
                - $signed({ref_alt_ff[vmc_pkg::ALT_W-1], ref_alt_ff});
      dt_calc   = time_ff - ref_time_ff;
      distance  = diff_ff[vmc_pkg::DIFF_W-1] ? vmc_pkg::DIFF_W'(-diff_ff)
                                             : vmc_pkg::DIFF_W'(diff_ff);
      div_req.start    = div_start;
      div_req.dividend = vmc_pkg::PROD_W'(distance) * vmc_pkg::PROD_W'(vmc_pkg::CM_TO_UM);
      div_req.divisor  = dt_ff;
   end

   vmc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Classification of the finished speed.
   always_comb begin
      if (dt_ff == '0) begin
         speed = '0;
      end else if (|div_rsp.quotient[vmc_pkg::PROD_W-1:vmc_pkg::SPEED_W]) begin
         speed = '1;
      end else begin
         speed = div_rsp.quotient[vmc_pkg::SPEED_W-1:0];
      end
      speed_ext = {1'b0, speed};
      tol_ext   = (vmc_pkg::SPEED_W + 1)'(tolerance_ff);
      refs_ext  = {1'b0, ref_speed_ff};
      diff_ext  = $signed({diff_ff[vmc_pkg::DIFF_W-1], diff_ff});
      thr_ext   = $signed((vmc_pkg::DIFF_W + 1)'(threshold_ff));

      if (diff_ext > thr_ext) begin
         new_dir = vmc_pkg::DIR_UP;
      end else if (diff_ext < -thr_ext) begin
         new_dir = vmc_pkg::DIR_DOWN;
      end else begin
         new_dir = vmc_pkg::DIR_NONE;
      end

      if (speed_ext > refs_ext + tol_ext) begin
         new_status = vmc_pkg::STATUS_ACCEL;
      end else if (speed_ext + tol_ext < refs_ext) begin
         new_status = vmc_pkg::STATUS_STOPPING;
      end else if (speed_ext < tol_ext) begin
         new_status = vmc_pkg::STATUS_STOPPED;
      end else begin
         new_status = vmc_pkg::STATUS_STEADY;
      end

      changed = (new_status != shown_status_ff) || (new_dir != shown_dir_ff);
   end

   // Control state, configuration, reference and reported values.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= vmc_pkg::ST_IDLE;
         enable_ff       <= vmc_pkg::ENABLE_RESET;
         threshold_ff    <= vmc_pkg::THRESHOLD_RESET;
         tolerance_ff    <= vmc_pkg::TOLERANCE_RESET;
         ref_alt_ff      <= '0;
         ref_time_ff     <= '0;
         ref_speed_ff    <= '0;
         primed_ff       <= 1'b0;
         shown_status_ff <= vmc_pkg::STATUS_STOPPED;
         shown_dir_ff    <= vmc_pkg::DIR_NONE;
         shown_speed_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_write) begin
            case (csr_index)
               vmc_pkg::CSR_ENABLE:    enable_ff    <= csr_data[0];
               vmc_pkg::CSR_THRESHOLD: threshold_ff <= csr_data[vmc_pkg::THR_W-1:0];
               vmc_pkg::CSR_TOLERANCE: tolerance_ff <= csr_data[vmc_pkg::TOL_W-1:0];
               default: begin
                  enable_ff <= enable_ff;
               end
            endcase
         end

         // The first sample after reset becomes the reference before it is classified.
         if (req_take && !primed_ff) begin
            ref_alt_ff   <= req_altitude_cm;
            ref_time_ff  <= now;
            ref_speed_ff <= '0;
            primed_ff    <= 1'b1;
         end

         if (cls_fire && changed) begin
            shown_status_ff <= new_status;
            shown_dir_ff    <= new_dir;
            shown_speed_ff  <= speed;
            ref_alt_ff      <= alt_ff;
            ref_time_ff     <= time_ff;
            ref_speed_ff    <= speed;
         end

         if (cls_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         alt_ff  <= req_altitude_cm;
         time_ff <= now;
      end
      if (state_ff == vmc_pkg::ST_DIFF) begin
         diff_ff <= diff_calc;
         dt_ff   <= dt_calc;
      end
      if (cls_fire) begin
         rsp_status_ff  <= changed ? new_status : shown_status_ff;
         rsp_dir_ff     <= changed ? new_dir : shown_dir_ff;
         rsp_speed_ff   <= changed ? speed : shown_speed_ff;
         rsp_changed_ff <= changed;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_motion_status    = rsp_status_ff;
   assign rsp_motion_direction = rsp_dir_ff;
   assign rsp_speed_out        = rsp_speed_ff;
   assign rsp_changed          = rsp_changed_ff;

endmodule

// ----- src/vmc_checker.sv -----
// Port-level assertions for the vertical motion classifier, with the bind to the top level.
module vmc_assertions (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_motion_status,
   input logic [1:0]                    rsp_motion_direction,
   input logic [vmc_pkg::SPEED_W-1:0]   rsp_speed_out,
   input logic                          rsp_changed
);

   // After reset the block is ready and holds no result.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("block not idle after reset");

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_motion_status)
         && $stable(rsp_motion_direction) && $stable(rsp_speed_out)
         && $stable(rsp_changed)))
      else $error("stalled result changed");

   // A result must pass the divider, so none appears right after a transaction is taken.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared one cycle after request");

   // A new result is produced only at the end of the work, when the block turns ready.
   a_rsp_at_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (req_ready && !$past(req_ready)))
      else $error("result appeared outside the end of a computation");

endmodule

bind vertical_motion_classifier vmc_assertions u_vmc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_motion_status    (rsp_motion_status),
   .rsp_motion_direction (rsp_motion_direction),
   .rsp_speed_out        (rsp_speed_out),
   .rsp_changed          (rsp_changed)
);
